### hw/rtl/lbse_pkg.sv
// Shared constants, types and the slot hash for the LZW byte stream encoder.
// No dependencies.
`timescale 1ns / 1ps
package lbse_pkg;
  localparam int DICT_ENTRIES = 32768;
  localparam int HASH_SLOTS   = 2 * DICT_ENTRIES;
  localparam int HASH_W       = $clog2(HASH_SLOTS);
  localparam int CNT_W        = $clog2(DICT_ENTRIES + 1);
  localparam int CODE_W       = 15;
  localparam int KEY_W        = 24;
  localparam int SLOT_W       = 1 + KEY_W + CODE_W;

  typedef enum logic [1:0] {
    LEN_EMPTY = 2'd0,
    LEN_ONE   = 2'd1,
    LEN_TWO   = 2'd2,
    LEN_CODE  = 2'd3
  } len_e;

  typedef struct packed {
    logic       load;
    logic       two;
    logic [7:0] b0;
    logic [7:0] b1;
  } emit_t;

  function automatic logic [HASH_W-1:0] hash_fn(input logic [KEY_W-1:0] k);
    return k[HASH_W-1:0] ^ k[KEY_W-1 -: HASH_W];
  endfunction
endpackage

### hw/rtl/lbse_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module lbse_ram #(
  parameter int W = 8,
  parameter int D = 256
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

### hw/rtl/lbse_out.sv
// Output word register for the LZW encoder: holds one or two result bytes.
// Depends on lbse_pkg.
`timescale 1ns / 1ps
module lbse_out (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lbse_pkg::emit_t emit_i,
  output logic            busy_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            run_last_o
);
  logic       valid_q, pend_q, last_q;
  logic [7:0] byte_q, next_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
      last_q  <= 1'b0;
    end else if (emit_i.load) begin
      valid_q <= 1'b1;
      pend_q  <= emit_i.two;
      last_q  <= !emit_i.two;
    end else if (valid_q && !out_stall_i) begin
      if (pend_q) begin
        pend_q <= 1'b0;
        last_q <= 1'b1;
      end else begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_i.load) begin
      byte_q <= emit_i.b0;
      next_q <= emit_i.b1;
    end else if (valid_q && !out_stall_i && pend_q) begin
      byte_q <= next_q;
    end
  end

  assign busy_o      = valid_q;
  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign run_last_o  = last_q;
endmodule

### hw/rtl/lzw_byte_stream_encoder_core.sv
// Top level of the LZW byte stream encoder: sequencer, hashed slot memory,
// output register. Depends on lbse_pkg, lbse_ram and lbse_out.
// The first byte after reset or flush is only stored; any other byte is accepted
// in S_IDLE, probes slots through S_RD and S_CMP, and on a miss goes to S_EMIT.
// No new byte is taken until S_IDLE returns, and S_EMIT waits while the output
// register is busy. The two bytes of a word go out back to back unless stalled.
// Reset and every flush sweep all HASH_SLOTS (65536) slots of the slot RAM, input stalled.
`timescale 1ns / 1ps
module lzw_byte_stream_encoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       command_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o
);
  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_RD, S_CMP, S_EMIT
  } state_e;

  state_e                           state_q;
  logic [lbse_pkg::HASH_W-1:0]      addr_q;
  logic [lbse_pkg::CNT_W-1:0]       count_q;
  logic [lbse_pkg::CODE_W-1:0]      prefix_q;
  lbse_pkg::len_e                   len_q;
  logic [7:0]                       first_q, second_q, c_q;
  logic                             flush_q;
  logic [lbse_pkg::KEY_W-1:0]       key_q;

  logic                             we;
  logic [lbse_pkg::HASH_W-1:0]      waddr;
  logic [lbse_pkg::SLOT_W-1:0]      wdata, rdata;
  logic                             slot_used, slot_hit, out_busy;
  logic [lbse_pkg::KEY_W-1:0]       key_d;
  lbse_pkg::emit_t                  emit;

  assign slot_used  = rdata[lbse_pkg::SLOT_W-1];
  assign slot_hit   = slot_used &&
                      (rdata[lbse_pkg::SLOT_W-2 -: lbse_pkg::KEY_W] == key_q);
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    if (len_q == lbse_pkg::LEN_ONE) begin
      key_d = {1'b1, 7'd0, first_q, data_byte_i};
    end else begin
      key_d = {1'b0, prefix_q, data_byte_i};
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = addr_q;
    wdata = '0;
    if (state_q == S_CLR) begin
      we = 1'b1;
    end else if (state_q == S_CMP && !slot_used &&
                 count_q < lbse_pkg::CNT_W'(lbse_pkg::DICT_ENTRIES)) begin
      we    = 1'b1;
      wdata = {1'b1, key_q, count_q[lbse_pkg::CODE_W-1:0]};
    end
  end

  always_comb begin
    emit      = '0;
    emit.load = (state_q == S_EMIT) && !out_busy && (len_q != lbse_pkg::LEN_EMPTY);
    case (len_q)
      lbse_pkg::LEN_ONE: begin
        emit.b0 = first_q;
      end
      lbse_pkg::LEN_TWO: begin
        emit.two = 1'b1;
        emit.b0  = first_q;
        emit.b1  = second_q;
      end
      lbse_pkg::LEN_CODE: begin
        emit.two = 1'b1;
        emit.b0  = {1'b1, prefix_q[lbse_pkg::CODE_W-1:8]};
        emit.b1  = prefix_q[7:0];
      end
      default: begin
        emit.b0 = first_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      addr_q   <= '0;
      count_q  <= '0;
      prefix_q <= '0;
      len_q    <= lbse_pkg::LEN_EMPTY;
      first_q  <= '0;
      second_q <= '0;
      c_q      <= '0;
      flush_q  <= 1'b0;
      key_q    <= '0;
    end else begin
      case (state_q)
        S_CLR: begin
          addr_q <= addr_q + 1'b1;
          if (addr_q == lbse_pkg::HASH_W'(lbse_pkg::HASH_SLOTS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            c_q     <= data_byte_i;
            flush_q <= command_i;
            key_q   <= key_d;
            addr_q  <= lbse_pkg::hash_fn(key_d);
            if (command_i) begin
              state_q <= S_EMIT;
            end else if (len_q == lbse_pkg::LEN_EMPTY) begin
              first_q <= data_byte_i;
              len_q   <= lbse_pkg::LEN_ONE;
            end else begin
              state_q <= S_RD;
            end
          end
        end
        S_RD: begin
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (slot_hit) begin
            prefix_q <= rdata[lbse_pkg::CODE_W-1:0];
            if (len_q == lbse_pkg::LEN_ONE) begin
              second_q <= c_q;
              len_q    <= lbse_pkg::LEN_TWO;
            end else begin
              len_q <= lbse_pkg::LEN_CODE;
            end
            state_q <= S_IDLE;
          end else if (slot_used) begin
            addr_q  <= addr_q + 1'b1;
            state_q <= S_RD;
          end else begin
            if (we) begin
              count_q <= count_q + 1'b1;
            end
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_busy || len_q == lbse_pkg::LEN_EMPTY) begin
            if (flush_q) begin
              count_q  <= '0;
              prefix_q <= '0;
              len_q    <= lbse_pkg::LEN_EMPTY;
              first_q  <= '0;
              second_q <= '0;
              addr_q   <= '0;
              state_q  <= S_CLR;
            end else begin
              first_q <= c_q;
              len_q   <= lbse_pkg::LEN_ONE;
              state_q <= S_IDLE;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  lbse_ram #(
    .W (lbse_pkg::SLOT_W),
    .D (lbse_pkg::HASH_SLOTS)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  lbse_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (emit),
    .busy_o      (out_busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o)
  );
endmodule
